/* src/trfs_pkg.sv */
// Package: shared types and codes for the tagged ring FIFO with search.
`default_nettype none
package trfs_pkg;

  // Operation codes carried on in_mode
  localparam logic [2:0] MODE_PUT_DATA  = 3'd0;
  localparam logic [2:0] MODE_PUT_EVENT = 3'd1;
  localparam logic [2:0] MODE_GET       = 3'd2;
  localparam logic [2:0] MODE_CLEAR     = 3'd3;
  localparam logic [2:0] MODE_SEARCH    = 3'd4;

  // Get result codes
  localparam logic [1:0] GOT_EMPTY = 2'd0;
  localparam logic [1:0] GOT_DATA  = 2'd1;
  localparam logic [1:0] GOT_EVENT = 2'd2;

  localparam int unsigned FILL_W = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_SEARCH
  } state_t;

  // One stored entry: tag (0 data, 1 event) and byte
  typedef struct packed {
    logic       tag;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    logic              accepted;
    logic              overflow;
    logic [1:0]        got_kind;
    logic [7:0]        read_value;
    logic              found;
    logic [FILL_W-1:0] fill_count;
    logic              last_echo;
  } res_t;

endpackage
`default_nettype wire

/* src/tagged_ring_fifo_with_search.sv */
// Top level: tagged ring FIFO of bytes with tag/byte search.
//
// Usage notes
// - Command channel: a word (in_mode, in_value, in_search_kind, in_put_last)
//   is taken at a rising edge with start high and busy low.
// - Result channel: each command gives exactly one result word, shown for a
//   single cycle with out_valid high. The receiver cannot hold it off.
// - Latency: puts, clear, unused modes, get of an empty queue and search of
//   an empty queue give their result in the cycle after acceptance; busy
//   stays low, so one such command per cycle is sustained.
// - Get of an occupied entry: one read of the entry store, during which
//   busy is high for one cycle.
// - Search: one stored entry examined per cycle through the single read
//   port of the store; busy stays high while the walk examines the entries
//   up to and including a match, or all of the queue (at most DEPTH-1).
// - Queue holds DEPTH-1 words; a put into a full queue empties it and
//   reports overflow. out_fill_count is the occupancy after the command.
// - Reset (rst_n low, synchronous) empties the queue and drops any result
//   in flight; store contents are not cleared and need no sweep.
`default_nettype none
module tagged_ring_fifo_with_search #(
  parameter int DEPTH = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_value,
  input  wire logic       in_search_kind,
  input  wire logic       in_put_last,
  output logic            out_valid,
  output logic            out_accepted,
  output logic            out_overflow,
  output logic [1:0]      out_got_kind,
  output logic [7:0]      out_read_value,
  output logic            out_found,
  output logic [9:0]      out_fill_count,
  output logic            out_last_echo
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  trfs_pkg::entry_t mem_wdata;
  trfs_pkg::entry_t mem_rdata;
  trfs_pkg::res_t   res;
  logic             res_valid;

  // entry store: tag + byte per slot
  trfs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // pointers, get/search sequencer, result word register
  trfs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_search_kind (in_search_kind),
    .in_put_last    (in_put_last),
    .busy           (busy),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res            (res)
  );

  assign out_valid      = res_valid;
  assign out_accepted   = res.accepted;
  assign out_overflow   = res.overflow;
  assign out_got_kind   = res.got_kind;
  assign out_read_value = res.read_value;
  assign out_found      = res.found;
  assign out_fill_count = res.fill_count;
  assign out_last_echo  = res.last_echo;

`ifndef SYNTHESIS
  // a put always answers in the next cycle
  a_put_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == trfs_pkg::MODE_PUT_DATA ||
                        in_mode == trfs_pkg::MODE_PUT_EVENT)) |=> out_valid)
    else $error("put gave no result in the following cycle");

  // a get either answers at once (empty) or goes busy for its read
  a_get_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == trfs_pkg::MODE_GET) |=> (out_valid || busy))
    else $error("get neither answered nor started its read");

  // a returned word only follows the store read cycle
  a_get_data_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_got_kind != trfs_pkg::GOT_EMPTY) |-> $past(busy))
    else $error("get word returned without a store read");

  // no result while a command is still being worked
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy) && $past(rst_n)) |-> !out_valid)
    else $error("result issued in the middle of a search walk");
`endif

endmodule
`default_nettype wire

/* src/trfs_mem.sv */
// Entry store: one write port, one read port, registered read data.
`default_nettype none
module trfs_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire trfs_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output trfs_pkg::entry_t     rd_data
);

  trfs_pkg::entry_t mem [DEPTH];
  trfs_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* src/trfs_ctrl.sv */
// Control: pointers, get/search sequencing and result register.
`default_nettype none
module trfs_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [2:0]       in_mode,
  input  wire logic [7:0]       in_value,
  input  wire logic             in_search_kind,
  input  wire logic             in_put_last,
  output logic                  busy,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output trfs_pkg::entry_t      mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  wire trfs_pkg::entry_t mem_rdata,
  output logic                  res_valid,
  output trfs_pkg::res_t        res
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

  trfs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [7:0]    key_val_r, key_val_nxt;
  logic          key_kind_r, key_kind_nxt;
  logic          res_valid_r, res_valid_nxt;
  trfs_pkg::res_t res_r, res_nxt;

  logic [AW-1:0] wr_adv, rd_adv, scan_adv;
  logic          acc, empty, hit;
  logic [AW:0]   fill;

  assign wr_adv   = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
  assign rd_adv   = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
  assign scan_adv = (scan_r   == LAST_IDX) ? '0 : scan_r + 1'b1;
  assign acc      = start && (state_r == trfs_pkg::ST_IDLE);
  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign hit      = (mem_rdata.tag == key_kind_r) && (mem_rdata.value == key_val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trfs_pkg::ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    key_val_r  <= key_val_nxt;
    key_kind_r <= key_kind_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    scan_nxt      = scan_r;
    key_val_nxt   = key_val_r;
    key_kind_nxt  = key_kind_r;
    res_valid_nxt = 1'b0;
    res_nxt       = '0;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r;
    mem_wdata     = '{tag: in_mode[0], value: in_value};
    // get and search both start at the oldest entry; the walk prefetches
    mem_raddr     = (state_r == trfs_pkg::ST_SEARCH) ? scan_adv : rd_ptr_r;

    unique case (state_r)
      trfs_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            trfs_pkg::MODE_PUT_DATA, trfs_pkg::MODE_PUT_EVENT: begin
              res_nxt.last_echo = (in_mode == trfs_pkg::MODE_PUT_DATA) && in_put_last;
              res_valid_nxt     = 1'b1;
              if (wr_adv == rd_ptr_r) begin
                wr_ptr_nxt       = '0;
                rd_ptr_nxt       = '0;
                res_nxt.overflow = 1'b1;
              end else begin
                mem_we           = 1'b1;
                wr_ptr_nxt       = wr_adv;
                res_nxt.accepted = 1'b1;
              end
            end
            trfs_pkg::MODE_GET: begin
              if (empty) begin
                res_valid_nxt = 1'b1;
              end else begin
                state_nxt = trfs_pkg::ST_GET;
              end
            end
            trfs_pkg::MODE_CLEAR: begin
              wr_ptr_nxt    = '0;
              rd_ptr_nxt    = '0;
              res_valid_nxt = 1'b1;
            end
            trfs_pkg::MODE_SEARCH: begin
              key_val_nxt  = in_value;
              key_kind_nxt = in_search_kind;
              if (empty) begin
                res_valid_nxt = 1'b1;
              end else begin
                scan_nxt  = rd_ptr_r;
                state_nxt = trfs_pkg::ST_SEARCH;
              end
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      trfs_pkg::ST_GET: begin
        res_nxt.got_kind   = mem_rdata.tag ? trfs_pkg::GOT_EVENT : trfs_pkg::GOT_DATA;
        res_nxt.read_value = mem_rdata.value;
        rd_ptr_nxt         = rd_adv;
        res_valid_nxt      = 1'b1;
        state_nxt          = trfs_pkg::ST_IDLE;
      end
      trfs_pkg::ST_SEARCH: begin
        if (hit) begin
          res_nxt.found = 1'b1;
          res_valid_nxt = 1'b1;
          state_nxt     = trfs_pkg::ST_IDLE;
        end else if (scan_adv == wr_ptr_r) begin
          res_valid_nxt = 1'b1;
          state_nxt     = trfs_pkg::ST_IDLE;
        end else begin
          scan_nxt = scan_adv;
        end
      end
      default: begin
        state_nxt = trfs_pkg::ST_IDLE;
      end
    endcase

    // fill after the step, modulo DEPTH
    fill = {1'b0, wr_ptr_nxt} - {1'b0, rd_ptr_nxt}
         + ((wr_ptr_nxt < rd_ptr_nxt) ? DEPTH_W : '0);
    res_nxt.fill_count = trfs_pkg::FILL_W'(fill);
  end

  assign busy      = (state_r != trfs_pkg::ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire
